// File: sv/mcma_pkg.sv
`default_nettype none

package mcma_pkg;

    localparam int DATA_W      = 32;
    localparam int CH_W        = 3;
    localparam int MODE_W      = 2;
    localparam int CNT_W       = 5;
    localparam int WIN_W       = 5;
    localparam int FACTOR_W    = 18;
    localparam int SUM_W       = DATA_W + CNT_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
    localparam int PROD_W      = DATA_W + FACTOR_W;
    localparam int FRAC_W      = 16;
    localparam int SCALED_W    = PROD_W - FRAC_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (CH_W + DATA_W + SCALED_W + CNT_W);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 18;
    localparam int WIN_CMP_W   = 9;

    localparam int DEF_CHANNELS = 8;
    localparam int DEF_DEPTH    = 16;

    localparam logic [WIN_W-1:0]    WINDOW_RST = 5'd16;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 18'd144480;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLR_ONE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLR_ALL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_WRITE,
        S_SUM,
        S_DIV,
        S_MUL,
        S_CLEAR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic meta_rd;
        logic clr_init_one;
        logic clr_init_all;
        logic clr_step;
        logic wr_add;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic add_ok;
        logic clr_one;
        logic clr_all;
        logic clr_done;
        logic sum_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: sv/mcma_ctrl.sv
`default_nettype none

module mcma_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mcma_pkg::t_status    i_st,
    output mcma_pkg::t_cmd       o_cmd,
    output logic                 o_item_ready
);
    import mcma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_st.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_st.in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_st.add_ok) begin
                    n_state = S_WRITE;
                end else if (i_st.clr_one || i_st.clr_all) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WRITE: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (i_st.sum_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_st.div_done) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_CLEAR: begin
                if (i_st.clr_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.accept = i_st.in_valid;
            end
            S_DISPATCH: begin
                o_cmd.meta_rd = 1'b1;
                if (!i_st.add_ok) begin
                    o_cmd.clr_init_one = i_st.clr_one;
                    o_cmd.clr_init_all = i_st.clr_all;
                end
            end
            S_WRITE: begin
                o_cmd.wr_add = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                o_cmd.div_init = i_st.sum_done;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_st.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/mcma_dp.sv
`default_nettype none

module mcma_dp #(
    parameter int CHANNELS = mcma_pkg::DEF_CHANNELS,
    parameter int DEPTH    = mcma_pkg::DEF_DEPTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  mcma_pkg::t_cmd                       i_cmd,
    output mcma_pkg::t_status                    o_st,
    input  wire                                  i_s_tvalid,
    input  wire  [mcma_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  wire  [mcma_pkg::MODE_W-1:0]          i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [mcma_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [mcma_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mcma_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mcma_pkg::*;

    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW     = $clog2(DEPTH);
    localparam int NWORDS = CHANNELS * DEPTH;
    localparam int AW     = $clog2(NWORDS);

    // configuration
    logic [WIN_W-1:0]    r_window;
    logic [FACTOR_W-1:0] r_factor;

    // item
    logic [MODE_W-1:0] r_mode;
    logic [CH_W-1:0]   r_ch;
    logic [DATA_W-1:0] r_sample;

    // storage
    logic [DATA_W-1:0] r_store    [NWORDS];
    logic [PW-1:0]     r_meta_ptr [CHANNELS];
    logic [CNT_W-1:0]  r_meta_cnt [CHANNELS];
    logic [PW-1:0]     r_ptr_q;
    logic [CNT_W-1:0]  r_cnt_q;
    logic [DATA_W-1:0] r_rdata;

    // clear sweep
    logic [CW-1:0] r_clr_ch;
    logic [PW-1:0] r_clr_idx;
    logic [CW-1:0] r_clr_last;

    // sum, divide, scale
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_rd_pend;
    logic [SUM_W-1:0]     r_acc;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PROD_W-1:0]    r_prod;

    // result register
    logic                r_out_valid;
    logic [CH_W-1:0]     r_out_ch;
    logic [DATA_W-1:0]   r_out_avg;
    logic [SCALED_W-1:0] r_out_scaled;
    logic [CNT_W-1:0]    r_out_cnt;

    logic                 ch_ok;
    logic                 add_ok;
    logic [CW-1:0]        ch_idx;
    logic [WIN_CMP_W-1:0] win_raw;
    logic [WIN_CMP_W-1:0] win_eff;
    logic [WIN_CMP_W-1:0] ptr_inc;
    logic [PW-1:0]        n_ptr;
    logic [CNT_W-1:0]     n_cnt;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        clr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 rd_issue;
    logic [CNT_W:0]       rem_sh;
    logic                 quo_bit;
    logic                 clr_done;
    logic                 out_free;

    assign o_cfg_ready = 1'b1;

    assign ch_ok  = int'(r_ch) < CHANNELS;
    assign add_ok = (r_mode == MODE_ADD) && ch_ok;
    assign ch_idx = CW'(r_ch);

    assign win_raw = (r_window == '0) ? WIN_CMP_W'(1) : WIN_CMP_W'(r_window);
    assign win_eff = (win_raw > WIN_CMP_W'(DEPTH)) ? WIN_CMP_W'(DEPTH) : win_raw;
    assign ptr_inc = WIN_CMP_W'(r_ptr_q) + WIN_CMP_W'(1);
    assign n_ptr   = (ptr_inc >= win_eff) ? '0 : PW'(ptr_inc);
    assign n_cnt   = (WIN_CMP_W'(r_cnt_q) < win_eff) ? r_cnt_q + CNT_W'(1) : r_cnt_q;

    assign wr_addr  = AW'(ch_idx) * AW'(DEPTH) + AW'(r_ptr_q);
    assign clr_addr = AW'(r_clr_ch) * AW'(DEPTH) + AW'(r_clr_idx);
    assign rd_addr  = AW'(ch_idx) * AW'(DEPTH) + AW'(r_idx);
    assign rd_issue = i_cmd.sum_step && (r_idx < r_cnt);

    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign quo_bit = rem_sh >= {1'b0, r_cnt};

    assign clr_done = (r_clr_idx == PW'(DEPTH - 1)) && (r_clr_ch == r_clr_last);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_st          = '0;
        o_st.in_valid = i_s_tvalid;
        o_st.add_ok   = add_ok;
        o_st.clr_one  = (r_mode == MODE_CLR_ONE) && ch_ok;
        o_st.clr_all  = (r_mode == MODE_CLR_ALL);
        o_st.clr_done = clr_done;
        o_st.sum_done = (r_idx == r_cnt) && !r_rd_pend;
        o_st.div_done = (r_div_cnt == DIV_CNT_W'(SUM_W));
        o_st.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_factor <= FACTOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                    r_window <= r_window;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_s_tuser;
            r_ch     <= i_s_tdata[CH_W-1:0];
            r_sample <= i_s_tdata[CH_W+DATA_W-1:CH_W];
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_store[wr_addr] <= r_sample;
        end else if (i_cmd.clr_step) begin
            r_store[clr_addr] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    // per-channel pointer and fill count
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_meta_ptr[ch_idx] <= n_ptr;
            r_meta_cnt[ch_idx] <= n_cnt;
        end else if (i_cmd.clr_step) begin
            r_meta_ptr[r_clr_ch] <= '0;
            r_meta_cnt[r_clr_ch] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.meta_rd && add_ok) begin
            r_ptr_q <= r_meta_ptr[ch_idx];
            r_cnt_q <= r_meta_cnt[ch_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ch   <= '0;
            r_clr_idx  <= '0;
            r_clr_last <= CW'(CHANNELS - 1);
        end else if (i_cmd.clr_init_one) begin
            r_clr_ch   <= ch_idx;
            r_clr_idx  <= '0;
            r_clr_last <= ch_idx;
        end else if (i_cmd.clr_init_all) begin
            r_clr_ch   <= '0;
            r_clr_idx  <= '0;
            r_clr_last <= CW'(CHANNELS - 1);
        end else if (i_cmd.clr_step && !clr_done) begin
            if (r_clr_idx == PW'(DEPTH - 1)) begin
                r_clr_idx <= '0;
                r_clr_ch  <= r_clr_ch + CW'(1);
            end else begin
                r_clr_idx <= r_clr_idx + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.wr_add) begin
                r_cnt     <= n_cnt;
                r_idx     <= '0;
                r_rd_pend <= 1'b0;
                r_rem     <= '0;
            end else if (i_cmd.sum_step) begin
                r_rd_pend <= rd_issue;
                if (rd_issue) r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= '0;
                r_rem     <= '0;
            end else if (i_cmd.div_step && (r_div_cnt != DIV_CNT_W'(SUM_W))) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                r_rem     <= quo_bit ? CNT_W'(rem_sh - {1'b0, r_cnt}) : rem_sh[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_add) begin
            r_acc <= '0;
        end else if (i_cmd.sum_step && r_rd_pend) begin
            r_acc <= r_acc + SUM_W'(r_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= r_acc;
        end else if (i_cmd.div_step && (r_div_cnt != DIV_CNT_W'(SUM_W))) begin
            r_quo <= {r_quo[SUM_W-2:0], quo_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_quo[DATA_W-1:0]) * PROD_W'(r_factor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ch     <= r_ch;
            r_out_avg    <= add_ok ? r_quo[DATA_W-1:0] : '0;
            r_out_scaled <= add_ok ? r_prod[PROD_W-1:FRAC_W] : '0;
            r_out_cnt    <= add_ok ? r_cnt : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_cnt, r_out_scaled, r_out_avg, r_out_ch};

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("sum index passed fill count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < r_cnt))
        else $error("divider remainder not below divisor");

    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_st.div_done |-> (r_quo[SUM_W-1:DATA_W] == '0))
        else $error("mean does not fit sample width");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_avg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: sv/multi_channel_moving_average_unit.sv
// Per-channel moving average of Q16.16 weight samples over a ring of up to
// DEPTH entries per channel. An add transfer writes the sample, then the
// unit reads the channel's filled entries one per cycle from the sample
// store, divides the sum by the fill count with a one-bit-per-cycle divider
// (37 steps) and scales the mean by the Q2.16 unit factor. Clearing one
// channel sweeps its DEPTH entries; clearing all sweeps CHANNELS * DEPTH
// entries. After reset the same full sweep of all CHANNELS * DEPTH entries
// runs before the first input transfer is taken; configuration writes are
// taken at any time. One item is in work at a time; a finished result
// waits in the output register while the next item is taken in.
`default_nettype none

module multi_channel_moving_average_unit #(
    parameter int CHANNELS = mcma_pkg::DEF_CHANNELS,
    parameter int DEPTH    = mcma_pkg::DEF_DEPTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] channel, [34:3] sample, rest zero
    input  wire  [mcma_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [1:0] mode
    input  wire  [mcma_pkg::MODE_W-1:0]       i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // [2:0] channel_out, [34:3] average, [68:35] average_scaled,
    // [73:69] fill_count, rest zero
    output logic [mcma_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mcma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [mcma_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mcma_pkg::*;

    t_cmd    cmd;
    t_status st;

    mcma_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_st         (st),
        .o_cmd        (cmd),
        .o_item_ready (o_s_tready)
    );

    mcma_dp #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire
